@@ design/dwpb_pkg.sv @@
// dwpb_pkg: request/result types, operation codes and fixed constants
// for the decayed weighted percentile buffer. No dependencies.
package dwpb_pkg;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [30:0] sample_value;
    logic [47:0] time_us;
    logic [47:0] begin_us;
    logic [6:0]  percentile;
  } in_req_t;

  typedef struct packed {
    logic        found;
    logic [30:0] result_value;
  } out_res_t;

  localparam logic [31:0] ONE_Q31     = 32'h8000_0000;
  localparam logic [31:0] DECAY_RESET = 32'd2122817694;
  localparam logic [20:0] US_PER_S    = 21'd1000000;
  // floor(2^51 / 1e6): applied to bits 47:16 of the age, estimate is exact or one low
  localparam logic [31:0] RECIP_US    = 32'd2251799813;
  localparam int          VAL_W       = 31;
  localparam int          WGT_W       = 32;
  localparam int          STAMP_W     = 48;

endpackage

@@ design/decayed_weighted_percentile_buffer.sv @@
// Decayed weighted percentile buffer: FIFO of stamped samples in two RAMs,
// per-entry decayed weights, percentile by bitwise search. Uses dwpb_pkg.
//
// Channel  | Ports                              | Handshake
// ---------+------------------------------------+-----------------------------
// request  | start, busy, in_req                | taken when start && !busy
// result   | out_strobe, out_res                | one cycle, cannot be held off
// config   | cfg_valid, cfg_ready, cfg_data     | written when valid && ready
//
// Add, clear, unused codes, query on empty FIFO: result strobes the cycle after
// the request. Query over N entries: a weigh pass (per entry: read, check,
// reciprocal divide by 1e6 and AGE_BITS square-and-multiply steps for stamps in
// range, write back), then, if any weight is nonzero and the percentile is at
// most 100, 31 search passes (N reads, drain, compare) and a post of the result.
// Reset (rst_n low, synchronous) empties the FIFO and restores the decay.
// The receiver cannot stall; busy is high for the whole of a query.
module decayed_weighted_percentile_buffer #(
  parameter int BUFFER_DEPTH = 256,
  parameter int AGE_BITS     = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  dwpb_pkg::in_req_t  in_req,
  output logic               out_strobe,
  output dwpb_pkg::out_res_t out_res,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_data
);
  import dwpb_pkg::*;

  localparam int PTR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
  localparam int SUM_W = WGT_W + CNT_W;
  localparam int CMP_W = SUM_W + 7;
  localparam int A_W   = VAL_W + WGT_W;
  localparam logic [32:0] AGE_MAX = (33'd1 << AGE_BITS) - 33'd1;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_WRD   = 9'b000000010,
    S_WCHK  = 9'b000000100,
    S_DIV   = 9'b000001000,
    S_POW   = 9'b000010000,
    S_WWR   = 9'b000100000,
    S_SSCAN = 9'b001000000,
    S_SCMP  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  // value+weight RAM and stamp RAM
  logic [A_W-1:0]     amem [BUFFER_DEPTH];
  logic [STAMP_W-1:0] bmem [BUFFER_DEPTH];

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [PTR_W-1:0]    oldest_r, oldest_nxt;
  logic [31:0]         decay_r, decay_nxt;
  in_req_t             req_r, req_nxt;
  logic [STAMP_W-1:0]  stamp_q;
  logic [VAL_W-1:0]    aval_q;
  logic [WGT_W-1:0]    awgt_q;
  logic [STAMP_W-1:0]  num_r, num_nxt;
  logic [31:0]         quo_r, quo_nxt;
  logic [5:0]          step_r, step_nxt;
  logic [31:0]         acc_r, acc_nxt, base_r, base_nxt;
  logic [AGE_BITS-1:0] age_r, age_nxt;
  logic [WGT_W-1:0]    wgt_r, wgt_nxt;
  logic [SUM_W-1:0]    total_r, total_nxt, cum_r, cum_nxt;
  logic [VAL_W-1:0]    largest_r, largest_nxt, ans_r, ans_nxt;
  logic                any_r, any_nxt, pv_r, pv_nxt;
  logic                out_strobe_r, out_strobe_nxt;
  out_res_t            out_res_r, out_res_nxt;

  logic                rd_en, b_we, a_we;
  logic [PTR_W-1:0]    rd_addr, a_waddr, rd_slot, add_slot;
  logic [A_W-1:0]      a_wdata;

  // combinational helpers
  logic [63:0]         recip_prod, quo_back;
  logic [STAMP_W-1:0]  div_rem;
  logic [31:0]         quo_fix;
  logic [AGE_BITS-1:0] age_sat;
  logic [31:0]         base_sat, acc_step;
  logic [63:0]         prod_a, prod_b;
  logic [VAL_W-1:0]    thr;
  logic                any_now, issue;
  logic [VAL_W-1:0]    largest_now;
  logic [CMP_W-1:0]    lhs, rhs;

  function automatic logic [PTR_W-1:0] wrap_slot(input logic [PTR_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (s >= (CNT_W+1)'(BUFFER_DEPTH)) s = s - (CNT_W+1)'(BUFFER_DEPTH);
    return s[PTR_W-1:0];
  endfunction

  assign busy       = (state_r != S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

  assign rd_slot  = wrap_slot(oldest_r, idx_r);
  assign add_slot = wrap_slot(oldest_r, cnt_r);

  // divide by 1e6: reciprocal estimate, then one correction step
  assign recip_prod = 64'(num_r[STAMP_W-1:16]) * 64'(RECIP_US);
  assign quo_back   = 64'(quo_r) * 64'(US_PER_S);
  assign div_rem    = num_r - quo_back[STAMP_W-1:0];
  assign quo_fix    = (div_rem >= STAMP_W'(US_PER_S)) ? quo_r + 32'd1 : quo_r;
  assign age_sat    = ({1'b0, quo_fix} > AGE_MAX) ? AGE_MAX[AGE_BITS-1:0]
                                                  : quo_fix[AGE_BITS-1:0];
  assign base_sat = (decay_r > ONE_Q31) ? ONE_Q31 : decay_r;

  // square-and-multiply, LSB first
  assign prod_a   = 64'(acc_r) * 64'(base_r);
  assign prod_b   = 64'(base_r) * 64'(base_r);
  assign acc_step = age_r[0] ? prod_a[62:31] : acc_r;

  assign thr = ans_r | ((VAL_W'(1) << step_r) - VAL_W'(1));
  assign lhs = CMP_W'(cum_r) * CMP_W'(100);
  assign rhs = CMP_W'(total_r) * CMP_W'(req_r.percentile);

  assign any_now     = any_r | (wgt_r != '0);
  assign largest_now = ((wgt_r != '0) && (!any_r || aval_q > largest_r)) ? aval_q
                                                                          : largest_r;
  assign issue = (idx_r < cnt_r);

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    oldest_nxt     = oldest_r;
    decay_nxt      = decay_r;
    req_nxt        = req_r;
    num_nxt        = num_r;
    quo_nxt        = quo_r;
    step_nxt       = step_r;
    acc_nxt        = acc_r;
    base_nxt       = base_r;
    age_nxt        = age_r;
    wgt_nxt        = wgt_r;
    total_nxt      = total_r;
    cum_nxt        = cum_r;
    largest_nxt    = largest_r;
    ans_nxt        = ans_r;
    any_nxt        = any_r;
    pv_nxt         = 1'b0;
    out_strobe_nxt = 1'b0;
    out_res_nxt    = '0;
    rd_en          = 1'b0;
    rd_addr        = rd_slot;
    a_we           = 1'b0;
    b_we           = 1'b0;
    a_waddr        = add_slot;
    a_wdata        = {in_req.sample_value, {WGT_W{1'b0}}};

    if (cfg_valid && cfg_ready) decay_nxt = cfg_data;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt = in_req;
          priority if (in_req.operation == OP_ADD) begin
            a_we = 1'b1;
            b_we = 1'b1;
            if (cnt_r >= CNT_W'(BUFFER_DEPTH)) begin
              // full: overwrite oldest and advance it
              a_waddr    = oldest_r;
              oldest_nxt = wrap_slot(oldest_r, CNT_W'(1));
            end else begin
              cnt_nxt = cnt_r + CNT_W'(1);
            end
            out_strobe_nxt = 1'b1;
          end else if (in_req.operation == OP_CLEAR) begin
            oldest_nxt     = '0;
            cnt_nxt        = '0;
            out_strobe_nxt = 1'b1;
          end else if (in_req.operation == OP_QUERY) begin
            idx_nxt     = '0;
            total_nxt   = '0;
            largest_nxt = '0;
            any_nxt     = 1'b0;
            if (cnt_r == '0) out_strobe_nxt = 1'b1;
            else state_nxt = S_WRD;
          end else begin
            out_strobe_nxt = 1'b1;
          end
        end
      end
      S_WRD: begin
        rd_en     = 1'b1;
        state_nxt = S_WCHK;
      end
      S_WCHK: begin
        priority if (stamp_q < req_r.begin_us) begin
          wgt_nxt   = '0;
          state_nxt = S_WWR;
        end else if (stamp_q > req_r.time_us) begin
          wgt_nxt   = ONE_Q31;
          state_nxt = S_WWR;
        end else begin
          num_nxt   = req_r.time_us - stamp_q;
          step_nxt  = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (step_r == '0) begin
          quo_nxt  = 32'(recip_prod[63:35]);
          step_nxt = 6'd1;
        end else begin
          acc_nxt   = ONE_Q31;
          base_nxt  = base_sat;
          age_nxt   = age_sat;
          step_nxt  = '0;
          state_nxt = S_POW;
        end
      end
      S_POW: begin
        acc_nxt  = acc_step;
        base_nxt = prod_b[62:31];
        age_nxt  = age_r >> 1;
        step_nxt = step_r + 6'd1;
        if (step_r == 6'(AGE_BITS - 1)) begin
          priority if (acc_step == '0) wgt_nxt = 32'd1;
          else if (acc_step > ONE_Q31) wgt_nxt = ONE_Q31;
          else wgt_nxt = acc_step;
          state_nxt = S_WWR;
        end
      end
      S_WWR: begin
        a_we        = 1'b1;
        a_waddr     = rd_slot;
        a_wdata     = {aval_q, wgt_r};
        total_nxt   = total_r + SUM_W'(wgt_r);
        largest_nxt = largest_now;
        any_nxt     = any_now;
        idx_nxt     = idx_r + CNT_W'(1);
        if (idx_nxt == cnt_r) begin
          priority if (!any_now) begin
            out_strobe_nxt = 1'b1;
            state_nxt      = S_IDLE;
          end else if (req_r.percentile > 7'd100) begin
            // no value can cross: largest qualifying value
            out_strobe_nxt = 1'b1;
            out_res_nxt    = '{found: 1'b1, result_value: largest_now};
            state_nxt      = S_IDLE;
          end else begin
            ans_nxt   = '0;
            cum_nxt   = '0;
            step_nxt  = 6'(VAL_W - 1);
            idx_nxt   = '0;
            state_nxt = S_SSCAN;
          end
        end else begin
          state_nxt = S_WRD;
        end
      end
      S_SSCAN: begin
        // stream reads, accumulate weight of entries at or below threshold
        rd_en  = issue;
        pv_nxt = issue;
        if (issue) idx_nxt = idx_r + CNT_W'(1);
        if (pv_r && (awgt_q != '0) && (aval_q <= thr)) cum_nxt = cum_r + SUM_W'(awgt_q);
        if (!issue && !pv_r) state_nxt = S_SCMP;
      end
      S_SCMP: begin
        // an empty prefix never qualifies: a zero percentile lands on a stored value
        if ((lhs < rhs) || (cum_r == '0)) ans_nxt = ans_r | (VAL_W'(1) << step_r);
        if (step_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          step_nxt  = step_r - 6'd1;
          cum_nxt   = '0;
          idx_nxt   = '0;
          state_nxt = S_SSCAN;
        end
      end
      S_DONE: begin
        out_strobe_nxt = 1'b1;
        out_res_nxt    = '{found: 1'b1, result_value: ans_r};
        state_nxt      = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      idx_r        <= '0;
      cnt_r        <= '0;
      oldest_r     <= '0;
      decay_r      <= DECAY_RESET;
      pv_r         <= 1'b0;
      any_r        <= 1'b0;
      out_strobe_r <= 1'b0;
      out_res_r    <= '0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      cnt_r        <= cnt_nxt;
      oldest_r     <= oldest_nxt;
      decay_r      <= decay_nxt;
      pv_r         <= pv_nxt;
      any_r        <= any_nxt;
      out_strobe_r <= out_strobe_nxt;
      out_res_r    <= out_res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    num_r     <= num_nxt;
    quo_r     <= quo_nxt;
    step_r    <= step_nxt;
    acc_r     <= acc_nxt;
    base_r    <= base_nxt;
    age_r     <= age_nxt;
    wgt_r     <= wgt_nxt;
    total_r   <= total_nxt;
    cum_r     <= cum_nxt;
    largest_r <= largest_nxt;
    ans_r     <= ans_nxt;
  end

  // RAMs: one write port, registered read
  always_ff @(posedge clk) begin
    if (a_we) amem[a_waddr] <= a_wdata;
    if (b_we) bmem[a_waddr] <= in_req.time_us;
    if (rd_en) begin
      {aval_q, awgt_q} <= amem[rd_addr];
      stamp_q          <= bmem[rd_addr];
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(BUFFER_DEPTH))
    else $error("entry count above depth");
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (CNT_W+1)'(oldest_r) < (CNT_W+1)'(BUFFER_DEPTH))
    else $error("oldest pointer out of range");
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_res.found |-> out_res.result_value == '0)
    else $error("nonzero value without found");
  a_wgt_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WWR |-> wgt_r <= ONE_Q31)
    else $error("weight above one");
  a_scan_rd: assert property (@(posedge clk) disable iff (!rst_n)
    pv_r |-> $past(state_r) == S_SSCAN)
    else $error("scan data without scan read");
`endif

endmodule
